/* sv/ckee_pkg.sv */
// Shared types and constants for the calculator key entry engine.
`timescale 1ns / 1ps
`default_nettype none
package ckee_pkg;

    localparam int WORD_BITS_DEF = 32;

    typedef enum logic [3:0] {
        K_DIGIT = 4'd0, K_BINOP = 4'd1, K_NOT = 4'd2, K_SIGN = 4'd3, K_ENTER = 4'd4,
        K_BACK = 4'd5, K_CLEAR = 4'd6, K_CLEAR_ALL = 4'd7, K_RADIX = 4'd8
    } kind_t;

    // Pending operator codes, op_code + 1.
    typedef enum logic [2:0] {
        P_NONE = 3'd0, P_ADD = 3'd1, P_SUB = 3'd2, P_MUL = 3'd3, P_DIV = 3'd4,
        P_AND = 3'd5, P_OR = 3'd6, P_XOR = 3'd7
    } pop_t;

    localparam logic [1:0] RADIX_BIN = 2'd0;
    localparam logic [1:0] RADIX_OCT = 2'd1;
    localparam logic [1:0] RADIX_DEC = 2'd2;
    localparam logic [1:0] RADIX_HEX = 2'd3;

    // Requested serial operation.
    typedef enum logic [1:0] {
        SOP_MUL = 2'd0, SOP_DIV = 2'd1
    } sop_t;

    typedef struct packed {
        logic start;
        sop_t op;
    } su_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'd0, ST_WAIT = 3'd1, ST_FIN = 3'd2, ST_OUT = 3'd3
    } state_t;

endpackage
`default_nettype wire

/* sv/ckee_serial_unit.sv */
// Bit-serial shift-add multiplier and restoring divider on unsigned words.
`timescale 1ns / 1ps
`default_nettype none
module ckee_serial_unit #(
    parameter int WORD_BITS = ckee_pkg::WORD_BITS_DEF
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire ckee_pkg::su_ctl_t ctl,
    input  wire [WORD_BITS-1:0]   a,
    input  wire [WORD_BITS-1:0]   b,
    output logic                  busy,
    output logic [WORD_BITS-1:0]  result
);
    localparam int CW = $clog2(WORD_BITS + 1);

    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    ckee_pkg::sop_t       op_reg, op_next;
    logic [WORD_BITS-1:0] acc_reg, acc_next;   // product or remainder
    logic [WORD_BITS-1:0] sh_reg, sh_next;     // multiplier or dividend/quotient
    logic [WORD_BITS-1:0] b_reg, b_next;
    logic [WORD_BITS:0]   trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        op_reg  <= op_next;
        acc_reg <= acc_next;
        sh_reg  <= sh_next;
        b_reg   <= b_next;
    end

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        acc_next  = acc_reg;
        sh_next   = sh_reg;
        b_next    = b_reg;
        trial     = {acc_reg, sh_reg[WORD_BITS-1]} - {1'b0, b_reg};
        if (ctl.start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(WORD_BITS);
            op_next   = ctl.op;
            acc_next  = '0;
            sh_next   = a;
            b_next    = b;
        end else if (busy_reg) begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) busy_next = 1'b0;
            if (op_reg == ckee_pkg::SOP_MUL) begin
                // Multiplier bits consumed from the top; product shifts left.
                acc_next = (acc_reg << 1) + (sh_reg[WORD_BITS-1] ? b_reg : '0);
                sh_next  = sh_reg << 1;
            end else if (!trial[WORD_BITS]) begin
                acc_next = trial[WORD_BITS-1:0];
                sh_next  = {sh_reg[WORD_BITS-2:0], 1'b1};
            end else begin
                acc_next = {acc_reg[WORD_BITS-2:0], sh_reg[WORD_BITS-1]};
                sh_next  = {sh_reg[WORD_BITS-2:0], 1'b0};
            end
        end
    end

    assign busy      = busy_reg;
    assign result    = (op_reg == ckee_pkg::SOP_MUL) ? acc_reg : sh_reg;
endmodule
`default_nettype wire

/* sv/calculator_key_entry_engine.sv */
// Top level of the calculator key entry engine.
`timescale 1ns / 1ps
`default_nettype none
// Usage: each keypad event arrives as one transaction on the s_ channel and
// yields exactly one transaction on the m_ channel describing the new display.
// s_axis_tdata carries kind, digit, op_code and radix_code; m_axis_tdata
// carries shown_value, shows_result, radix_now, divide_error and history_push.
// The block handles one event at a time. Valid digits, backspace and a pending
// multiply, or a divide by a nonzero entry, go through a bit-serial unit that
// retires one bit per cycle. A digit that passes its guard uses two serial
// passes (a guard divide and a multiply).
// The result sits in an output register until taken; while the receiver
// stalls, s_axis_tready stays low and no state changes. Synchronous
// active-low reset returns the entry, accumulator, pending operator and mode
// flags to zero, the radix to decimal and drops m_axis_tvalid.
module calculator_key_entry_engine #(
    parameter int WORD_BITS = ckee_pkg::WORD_BITS_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // kind[3:0], digit[7:4], op_code[10:8], radix_code[12:11], zeros
    input  wire [15:0]  s_axis_tdata,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // shown_value[31:0], shows_result[32], radix_now[34:33],
    // divide_error[35], history_push[36], zeros
    output logic [39:0] m_axis_tdata
);
    localparam int W = WORD_BITS;
    localparam logic [W-1:0] WMASK = '1;
    localparam logic [W-1:0] WSMAX = WMASK >> 1;

    ckee_pkg::state_t st_reg, st_next;
    // Serial pass phase: 0 main op, 1 digit guard divide, 2 digit multiply.
    logic [1:0]  ph_reg, ph_next;
    logic [3:0]  kind_reg, kind_next;
    logic [3:0]  dig_reg, dig_next;
    logic [2:0]  opc_reg, opc_next;
    logic [1:0]  rc_reg, rc_next;

    logic [W-1:0] entry_reg, entry_next;
    logic [W-1:0] acc_reg, acc_next;
    logic [1:0]   radix_reg, radix_next;
    logic [2:0]   pend_reg, pend_next;
    logic         show_reg, show_next, cod_reg, cod_next;
    logic         chain_reg, chain_next, after_reg, after_next;
    logic         derr_reg, derr_next, hist_reg, hist_next;
    logic         mval_reg, mval_next;
    logic [39:0]  mdata_reg, mdata_next;

    ckee_pkg::su_ctl_t su_ctl;
    logic [W-1:0] su_a, su_b, su_res;
    logic         su_busy;
    logic         neg_a, neg_b;
    logic [W-1:0] mag_a, mag_b, r, shown, radix_w, limit, ent_eff;
    logic [4:0]   radix_v;
    logic         do_op, sdiv, div_neg;
    logic         sign_r_reg, sign_r_next;

    ckee_serial_unit #(.WORD_BITS(W)) u_ser (
        .aclk(aclk), .aresetn(aresetn), .ctl(su_ctl), .a(su_a), .b(su_b),
        .busy(su_busy), .result(su_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= ckee_pkg::ST_IDLE;
            entry_reg <= '0;
            acc_reg   <= '0;
            radix_reg <= ckee_pkg::RADIX_DEC;
            pend_reg  <= ckee_pkg::P_NONE;
            show_reg  <= 1'b0;
            cod_reg   <= 1'b0;
            chain_reg <= 1'b0;
            after_reg <= 1'b0;
            mval_reg  <= 1'b0;
        end else begin
            st_reg    <= st_next;
            entry_reg <= entry_next;
            acc_reg   <= acc_next;
            radix_reg <= radix_next;
            pend_reg  <= pend_next;
            show_reg  <= show_next;
            cod_reg   <= cod_next;
            chain_reg <= chain_next;
            after_reg <= after_next;
            mval_reg  <= mval_next;
        end
        ph_reg     <= ph_next;
        kind_reg   <= kind_next;
        dig_reg    <= dig_next;
        opc_reg    <= opc_next;
        rc_reg     <= rc_next;
        derr_reg   <= derr_next;
        hist_reg   <= hist_next;
        mdata_reg  <= mdata_next;
        sign_r_reg <= sign_r_next;
    end

    always_comb begin
        case (radix_reg)
            ckee_pkg::RADIX_BIN: radix_v = 5'd2;
            ckee_pkg::RADIX_OCT: radix_v = 5'd8;
            ckee_pkg::RADIX_DEC: radix_v = 5'd10;
            default:             radix_v = 5'd16;
        endcase
        radix_w = W'(radix_v);
        limit   = (radix_reg == ckee_pkg::RADIX_DEC) ? WSMAX : WMASK;
        neg_a   = acc_reg[W-1];
        neg_b   = entry_reg[W-1];
        mag_a   = neg_a ? (W'(0) - acc_reg) : acc_reg;
        mag_b   = neg_b ? (W'(0) - entry_reg) : entry_reg;
        ent_eff = cod_reg ? '0 : entry_reg;
    end

    // Combinational result of a non-serial pending operator.
    always_comb begin
        case (pend_reg)
            ckee_pkg::P_ADD: r = acc_reg + entry_reg;
            ckee_pkg::P_SUB: r = acc_reg - entry_reg;
            ckee_pkg::P_AND: r = acc_reg & entry_reg;
            ckee_pkg::P_OR:  r = acc_reg | entry_reg;
            ckee_pkg::P_XOR: r = acc_reg ^ entry_reg;
            default:         r = acc_reg;
        endcase
    end

    always_comb begin
        st_next     = st_reg;
        ph_next     = ph_reg;
        kind_next   = kind_reg;
        dig_next    = dig_reg;
        opc_next    = opc_reg;
        rc_next     = rc_reg;
        entry_next  = entry_reg;
        acc_next    = acc_reg;
        radix_next  = radix_reg;
        pend_next   = pend_reg;
        show_next   = show_reg;
        cod_next    = cod_reg;
        chain_next  = chain_reg;
        after_next  = after_reg;
        derr_next   = derr_reg;
        hist_next   = hist_reg;
        mval_next   = mval_reg;
        mdata_next  = mdata_reg;
        sign_r_next = sign_r_reg;
        su_ctl      = '{start: 1'b0, op: ckee_pkg::SOP_MUL};
        su_a        = '0;
        su_b        = '0;
        s_axis_tready = 1'b0;
        do_op       = 1'b0;
        sdiv        = 1'b0;
        div_neg     = neg_a ^ neg_b;
        shown       = show_reg ? acc_reg : entry_reg;

        case (st_reg)
            ckee_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    kind_next = s_axis_tdata[3:0];
                    dig_next  = s_axis_tdata[7:4];
                    opc_next  = s_axis_tdata[10:8];
                    rc_next   = s_axis_tdata[12:11];
                    derr_next = 1'b0;
                    hist_next = 1'b0;
                    st_next   = ckee_pkg::ST_WAIT;
                    ph_next   = 2'd0;
                end
            end
            ckee_pkg::ST_WAIT: begin
                // Launch serial work where needed, otherwise finish now.
                st_next = ckee_pkg::ST_FIN;
                if (kind_reg == ckee_pkg::K_DIGIT && W'(dig_reg) < radix_w) begin
                    su_ctl = '{start: 1'b1, op: ckee_pkg::SOP_DIV};
                    su_a = limit - W'(dig_reg);
                    su_b = radix_w;
                    ph_next = 2'd1;
                end else if (kind_reg == ckee_pkg::K_BACK) begin
                    su_ctl = '{start: 1'b1, op: ckee_pkg::SOP_DIV};
                    su_a = entry_reg;
                    su_b = radix_w;
                end else if ((kind_reg == ckee_pkg::K_BINOP && chain_reg)
                             || kind_reg == ckee_pkg::K_ENTER) begin
                    if (pend_reg == ckee_pkg::P_MUL) begin
                        su_ctl = '{start: 1'b1, op: ckee_pkg::SOP_MUL};
                        su_a = acc_reg;
                        su_b = entry_reg;
                    end else if (pend_reg == ckee_pkg::P_DIV && entry_reg != '0) begin
                        su_ctl = '{start: 1'b1, op: ckee_pkg::SOP_DIV};
                        su_a = mag_a;
                        su_b = mag_b;
                        sign_r_next = div_neg;
                    end
                end
            end
            ckee_pkg::ST_FIN: begin
                if (!su_busy) begin
                    st_next = ckee_pkg::ST_OUT;
                    case (kind_reg)
                        ckee_pkg::K_DIGIT: begin
                            if (ph_reg == 2'd1) begin
                                // Guard result ready: apply the side effects.
                                entry_next = ent_eff;
                                cod_next   = 1'b0;
                                show_next  = 1'b0;
                                if (after_reg) pend_next = ckee_pkg::P_NONE;
                                if (!(su_res < ent_eff)) begin
                                    su_ctl = '{start: 1'b1, op: ckee_pkg::SOP_MUL};
                                    su_a = ent_eff;
                                    su_b = radix_w;
                                    ph_next = 2'd2;
                                    st_next = ckee_pkg::ST_FIN;
                                end
                            end else if (ph_reg == 2'd2) begin
                                entry_next = su_res + W'(dig_reg);
                                after_next = 1'b0;
                            end
                        end
                        ckee_pkg::K_BINOP: begin
                            if (pend_reg != ckee_pkg::P_NONE) begin
                                if (chain_reg) do_op = 1'b1;
                            end else begin
                                acc_next = entry_reg;
                            end
                            if (do_op && pend_reg == ckee_pkg::P_DIV
                                && entry_reg == '0) begin
                                derr_next = 1'b1;
                            end else begin
                                if (opc_reg != 3'd7) pend_next = opc_reg + 3'd1;
                                show_next  = 1'b1;
                                cod_next   = 1'b1;
                                chain_next = 1'b1;
                                after_next = 1'b0;
                            end
                        end
                        ckee_pkg::K_NOT: begin
                            if (show_reg) acc_next = ~acc_reg;
                            else entry_next = ~entry_reg;
                            cod_next   = 1'b1;
                            after_next = 1'b1;
                        end
                        ckee_pkg::K_SIGN: begin
                            if (show_reg) acc_next = W'(0) - acc_reg;
                            else entry_next = W'(0) - entry_reg;
                        end
                        ckee_pkg::K_ENTER: begin
                            if (pend_reg == ckee_pkg::P_DIV && entry_reg == '0) begin
                                derr_next = 1'b1;
                            end else begin
                                if (pend_reg != ckee_pkg::P_NONE) begin
                                    do_op     = 1'b1;
                                    show_next = 1'b1;
                                    cod_next  = 1'b1;
                                end
                                chain_next = 1'b0;
                                after_next = 1'b1;
                                hist_next  = 1'b1;
                            end
                        end
                        ckee_pkg::K_BACK: entry_next = su_res;
                        ckee_pkg::K_CLEAR: begin
                            entry_next = '0;
                            cod_next   = 1'b0;
                        end
                        ckee_pkg::K_CLEAR_ALL: begin
                            entry_next = '0;
                            acc_next   = '0;
                            radix_next = ckee_pkg::RADIX_DEC;
                            pend_next  = ckee_pkg::P_NONE;
                            show_next  = 1'b0;
                            cod_next   = 1'b0;
                            chain_next = 1'b0;
                            after_next = 1'b0;
                        end
                        ckee_pkg::K_RADIX: radix_next = rc_reg;
                        default: ;
                    endcase
                    if (do_op && !derr_next) begin
                        sdiv = (pend_reg == ckee_pkg::P_DIV);
                        if (pend_reg == ckee_pkg::P_MUL) acc_next = su_res;
                        else if (sdiv)
                            acc_next = sign_r_reg ? (W'(0) - su_res) : su_res;
                        else acc_next = r;
                    end
                end
            end
            ckee_pkg::ST_OUT: begin
                if (!mval_reg) begin
                    shown = show_reg ? acc_reg : entry_reg;
                    mdata_next = {3'b000, hist_reg, derr_reg, radix_reg, show_reg,
                                  32'(signed'(shown))};
                    mval_next = 1'b1;
                end else if (m_axis_tready) begin
                    mval_next = 1'b0;
                    st_next   = ckee_pkg::ST_IDLE;
                end
            end
            default: st_next = ckee_pkg::ST_IDLE;
        endcase
    end

    assign m_axis_tvalid = mval_reg;
    assign m_axis_tdata  = mdata_reg;
endmodule
`default_nettype wire

/* sv/ckee_checker.sv */
// Port-level checker for the calculator key entry engine, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module ckee_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [39:0] m_axis_tdata
);
    // One event at a time: no acceptance while a result is pending.
    a_no_accept_with_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !s_axis_tready) else $error("input taken with result pending");
    // A stalled result holds its data.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
    // An accepted event cannot produce a result in the very next cycle.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid)
        else $error("result too early");
    // Divide error and history push never appear together; padding is zero.
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (!(m_axis_tdata[35] && m_axis_tdata[36])
                           && m_axis_tdata[39:37] == 3'b000))
        else $error("bad result flags");
endmodule

bind calculator_key_entry_engine ckee_checker u_ckee_checker (
    .aclk(aclk), .aresetn(aresetn), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire
